### sv/conv_weight_layout_reorder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the convolution weight layout reorder block
// Shared concurrent property forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CONV_WEIGHT_LAYOUT_REORDER_DEFINES_SVH
`define CONV_WEIGHT_LAYOUT_REORDER_DEFINES_SVH

// Same-cycle implication
`define CWR_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cwr: same-cycle property failed");

// Next-cycle implication
`define CWR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cwr: next-cycle property failed");

`endif

### sv/cwr_pkg.sv
// ----------------------------------------------------------------------------
// cwr_pkg
// Widths, reset values, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cwr_pkg;

	// Field and register widths
	localparam int VALUE_W    = 8;
	localparam int ADDR_W     = 28;
	localparam int KDIM_REG_W = 5;
	localparam int CHAN_REG_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;

	// Default size limits
	localparam int MAX_KERNEL_DIM = 16;
	localparam int MAX_CHANNELS   = 1024;

	// Register reset values
	localparam logic [KDIM_REG_W-1:0] KERNEL_HEIGHT_RST = KDIM_REG_W'(3);
	localparam logic [KDIM_REG_W-1:0] KERNEL_WIDTH_RST  = KDIM_REG_W'(3);
	localparam logic [CHAN_REG_W-1:0] CHANNELS_IN_RST   = CHAN_REG_W'(1);
	localparam logic [CHAN_REG_W-1:0] CHANNELS_OUT_RST  = CHAN_REG_W'(1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_HEIGHT = 2'd0,
		REG_KERNEL_WIDTH  = 2'd1,
		REG_CHANNELS_IN   = 2'd2,
		REG_CHANNELS_OUT  = 2'd3
	} cfg_reg_t;

	// Multiply-add step selector: which size and position enter the unit
	typedef enum logic [1:0] {
		SEL_CHANNELS = 2'd0,
		SEL_ROWS     = 2'd1,
		SEL_COLS     = 2'd2
	} calc_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      calc;
		calc_sel_t sel;
		logic      emit;
	} cwr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} cwr_status_t;

endpackage

### sv/cwr_ctrl.sv
// ----------------------------------------------------------------------------
// cwr_ctrl
// Sequencer: takes an item, runs three multiply-add steps, then emits.
// ----------------------------------------------------------------------------
module cwr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  cwr_pkg::cwr_status_t status,
	output cwr_pkg::cwr_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t              state_q;
	cwr_pkg::calc_sel_t  step_q;

	// Hold state and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= cwr_pkg::SEL_CHANNELS;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CALC;
						step_q  <= cwr_pkg::SEL_CHANNELS;
					end
				end
				ST_CALC: begin
					unique case (step_q)
						cwr_pkg::SEL_CHANNELS: step_q <= cwr_pkg::SEL_ROWS;
						cwr_pkg::SEL_ROWS:     step_q <= cwr_pkg::SEL_COLS;
						default: begin
							step_q  <= cwr_pkg::SEL_CHANNELS;
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode commands from state
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_IDLE) && s_tvalid;
		cmd.calc  = (state_q == ST_CALC);
		cmd.sel   = step_q;
		cmd.emit  = (state_q == ST_EMIT) && status.out_free;
	end

endmodule

### sv/cwr_datapath.sv
// ----------------------------------------------------------------------------
// cwr_datapath
// Size registers, position counters, shared multiply-add and output register.
// ----------------------------------------------------------------------------
module cwr_datapath #(
	parameter int MAX_KERNEL_DIM = cwr_pkg::MAX_KERNEL_DIM,
	parameter int MAX_CHANNELS   = cwr_pkg::MAX_CHANNELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cwr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cwr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [cwr_pkg::VALUE_W-1:0]       weight_value,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [cwr_pkg::ADDR_W-1:0]        dest_address,
	output logic [cwr_pkg::VALUE_W-1:0]       dest_value,
	output logic                              tensor_last,
	input  cwr_pkg::cwr_cmd_t                 cmd,
	output cwr_pkg::cwr_status_t              status
);

	localparam int ADDR_W = cwr_pkg::ADDR_W;
	localparam int KPOS_W = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
	localparam int CPOS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int KSZ_W  = $clog2(MAX_KERNEL_DIM + 1);
	localparam int CSZ_W  = $clog2(MAX_CHANNELS + 1);
	localparam int SZ_W   = (KSZ_W > CSZ_W) ? KSZ_W : CSZ_W;
	localparam int POS_W  = (KPOS_W > CPOS_W) ? KPOS_W : CPOS_W;

	// Configuration registers
	logic [cwr_pkg::KDIM_REG_W-1:0] kernel_height_q, kernel_width_q;
	logic [cwr_pkg::CHAN_REG_W-1:0] channels_in_q, channels_out_q;

	// Position counters
	logic [KPOS_W-1:0] col_pos_q, row_pos_q;
	logic [CPOS_W-1:0] inch_pos_q, outch_pos_q;

	// Working registers
	logic [ADDR_W-1:0]           acc_q;
	logic [cwr_pkg::VALUE_W-1:0] value_q;

	// Output register
	logic                        out_valid_q;
	logic [ADDR_W-1:0]           out_addr_q;
	logic [cwr_pkg::VALUE_W-1:0] out_value_q;
	logic                        out_last_q;

	logic [KSZ_W-1:0] h_eff, w_eff;
	logic [CSZ_W-1:0] ci_eff, co_eff;
	logic             col_end, row_end, inch_end, outch_end;
	logic [SZ_W-1:0]  mul_size;
	logic [POS_W-1:0] mul_pos;
	logic [ADDR_W+SZ_W-1:0] product;
	logic [ADDR_W-1:0] acc_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_height_q <= cwr_pkg::KERNEL_HEIGHT_RST;
			kernel_width_q  <= cwr_pkg::KERNEL_WIDTH_RST;
			channels_in_q   <= cwr_pkg::CHANNELS_IN_RST;
			channels_out_q  <= cwr_pkg::CHANNELS_OUT_RST;
		end else if (cfg_we) begin
			unique case (cwr_pkg::cfg_reg_t'(cfg_index))
				cwr_pkg::REG_KERNEL_HEIGHT:
					kernel_height_q <= cfg_data[cwr_pkg::KDIM_REG_W-1:0];
				cwr_pkg::REG_KERNEL_WIDTH:
					kernel_width_q  <= cfg_data[cwr_pkg::KDIM_REG_W-1:0];
				cwr_pkg::REG_CHANNELS_IN:
					channels_in_q   <= cfg_data[cwr_pkg::CHAN_REG_W-1:0];
				cwr_pkg::REG_CHANNELS_OUT:
					channels_out_q  <= cfg_data[cwr_pkg::CHAN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp sizes: zero acts as one, oversize acts as the limit
	always_comb begin
		if (kernel_height_q == '0)
			h_eff = KSZ_W'(1);
		else if (32'(kernel_height_q) > 32'(MAX_KERNEL_DIM))
			h_eff = KSZ_W'(MAX_KERNEL_DIM);
		else
			h_eff = KSZ_W'(kernel_height_q);

		if (kernel_width_q == '0)
			w_eff = KSZ_W'(1);
		else if (32'(kernel_width_q) > 32'(MAX_KERNEL_DIM))
			w_eff = KSZ_W'(MAX_KERNEL_DIM);
		else
			w_eff = KSZ_W'(kernel_width_q);

		if (channels_in_q == '0)
			ci_eff = CSZ_W'(1);
		else if (32'(channels_in_q) > 32'(MAX_CHANNELS))
			ci_eff = CSZ_W'(MAX_CHANNELS);
		else
			ci_eff = CSZ_W'(channels_in_q);

		if (channels_out_q == '0)
			co_eff = CSZ_W'(1);
		else if (32'(channels_out_q) > 32'(MAX_CHANNELS))
			co_eff = CSZ_W'(MAX_CHANNELS);
		else
			co_eff = CSZ_W'(channels_out_q);
	end

	// Detect counters at or past their last position
	assign inch_end  = (32'(inch_pos_q) + 32'd1) >= 32'(ci_eff);
	assign col_end   = (32'(col_pos_q) + 32'd1) >= 32'(w_eff);
	assign row_end   = (32'(row_pos_q) + 32'd1) >= 32'(h_eff);
	assign outch_end = (32'(outch_pos_q) + 32'd1) >= 32'(co_eff);

	// Select the operands of the shared multiply-add
	always_comb begin
		unique case (cmd.sel)
			cwr_pkg::SEL_CHANNELS: begin
				mul_size = SZ_W'(ci_eff);
				mul_pos  = POS_W'(inch_pos_q);
			end
			cwr_pkg::SEL_ROWS: begin
				mul_size = SZ_W'(h_eff);
				mul_pos  = POS_W'(row_pos_q);
			end
			default: begin
				mul_size = SZ_W'(w_eff);
				mul_pos  = POS_W'(col_pos_q);
			end
		endcase
	end

	// Address is kept modulo the address width at every step
	assign product  = (ADDR_W+SZ_W)'(acc_q) * (ADDR_W+SZ_W)'(mul_size);
	assign acc_next = product[ADDR_W-1:0] + ADDR_W'(mul_pos);

	// Capture the item, then fold in one dimension per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q   <= ADDR_W'(outch_pos_q);
			value_q <= weight_value;
		end else if (cmd.calc) begin
			acc_q <= acc_next;
		end
	end

	// Advance position counters on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q   <= '0;
			row_pos_q   <= '0;
			inch_pos_q  <= '0;
			outch_pos_q <= '0;
		end else if (cmd.emit) begin
			if (!inch_end) begin
				inch_pos_q <= inch_pos_q + CPOS_W'(1);
			end else begin
				inch_pos_q <= '0;
				if (!col_end) begin
					col_pos_q <= col_pos_q + KPOS_W'(1);
				end else begin
					col_pos_q <= '0;
					if (!row_end) begin
						row_pos_q <= row_pos_q + KPOS_W'(1);
					end else begin
						row_pos_q <= '0;
						if (!outch_end)
							outch_pos_q <= outch_pos_q + CPOS_W'(1);
						else
							outch_pos_q <= '0;
					end
				end
			end
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q  <= acc_q;
			out_value_q <= value_q;
			out_last_q  <= inch_end && col_end && row_end && outch_end;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign dest_address    = out_addr_q;
	assign dest_value      = out_value_q;
	assign tensor_last     = out_last_q;

endmodule

### sv/conv_weight_layout_reorder.sv
// ----------------------------------------------------------------------------
// conv_weight_layout_reorder
// Weight stream in OHWI order out as values with their OIHW element address.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one signed 8-bit weight per item, in-channel fastest, then
//   column, row and out-channel. m_* returns one item per weight: the
//   destination address, the weight unchanged, and tlast on the final
//   weight of the tensor, after which all positions return to zero.
//   cfg_we/cfg_index/cfg_data set kernel height, kernel width, input and
//   output channel counts; write them only while no item is in flight.
//   An accepted item is captured, then folded through the shared multiply-add
//   unit one dimension of the address per cycle (3 steps), then emitted to
//   the output register; the input stays closed until that emit, so a new
//   item is taken only after the last one has been emitted.
//   The output register holds a result while the receiver stalls; the next
//   item is still accepted and computed, and waits to emit until the
//   register frees.
//   Reset clears the positions, restores 3x3 kernels with one channel in
//   and out, and empties the output register.
// ----------------------------------------------------------------------------
`include "conv_weight_layout_reorder_defines.svh"

module conv_weight_layout_reorder #(
	parameter int MAX_KERNEL_DIM = cwr_pkg::MAX_KERNEL_DIM,
	parameter int MAX_CHANNELS   = cwr_pkg::MAX_CHANNELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cwr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cwr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cwr_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] weight_value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cwr_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [27:0] dest_address,
	                                                     // [35:28] dest_value, rest zero
	output logic                               m_tlast   // tensor_last
);

	cwr_pkg::cwr_cmd_t    cmd;
	cwr_pkg::cwr_status_t status;

	logic [cwr_pkg::ADDR_W-1:0]  dest_address;
	logic [cwr_pkg::VALUE_W-1:0] dest_value;

	cwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cwr_datapath #(
		.MAX_KERNEL_DIM (MAX_KERNEL_DIM),
		.MAX_CHANNELS   (MAX_CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.weight_value (s_tdata[cwr_pkg::VALUE_W-1:0]),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.dest_address (dest_address),
		.dest_value   (dest_value),
		.tensor_last  (m_tlast),
		.cmd          (cmd),
		.status       (status)
	);

	// Pack the result fields: zero padding highest, address lowest
	assign m_tdata = {
		(cwr_pkg::OUT_TDATA_W - cwr_pkg::ADDR_W - cwr_pkg::VALUE_W)'(0),
		dest_value,
		dest_address
	};

	// An accepted item keeps the input closed on the next cycle
	`CWR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// Never overwrite a result the receiver has not taken
	`CWR_ASSERT_SAME(a_emit_only_when_free, cmd.emit, !m_tvalid || m_tready)
	// An emitted result is presented on the next cycle
	`CWR_ASSERT_NEXT(a_emit_shows_valid, cmd.emit, m_tvalid)
	// Load happens only on an input handshake
	`CWR_ASSERT_SAME(a_load_on_accept, cmd.load, s_tvalid && s_tready)

endmodule

### dv/tb_conv_weight_layout_reorder.sv
// ----------------------------------------------------------------------------
// tb_conv_weight_layout_reorder
// Self-checking testbench for the OHWI to OIHW weight address reorder block.
// A directed table covers the reset sizes, sizes of zero, over-range sizes,
// the largest sizes and a resize in the middle of a tensor. Random phases
// follow with small whole tensors, extreme and partial register writes, and
// counter sweeps. Items are checked against typed table results or a cycle-free
// counter model; random phases rotate four sender/receiver flow patterns.
// ----------------------------------------------------------------------------
module tb_conv_weight_layout_reorder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W         = cwr_pkg::ADDR_W;
	localparam int VALUE_W        = cwr_pkg::VALUE_W;
	localparam int CFG_IDX_W      = cwr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W     = cwr_pkg::CFG_DATA_W;
	localparam int KDIM_REG_W     = cwr_pkg::KDIM_REG_W;
	localparam int CHAN_REG_W     = cwr_pkg::CHAN_REG_W;
	localparam int IN_TDATA_W     = cwr_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W    = cwr_pkg::OUT_TDATA_W;
	localparam int MAX_KERNEL_DIM = cwr_pkg::MAX_KERNEL_DIM;
	localparam int MAX_CHANNELS   = cwr_pkg::MAX_CHANNELS;

	localparam int ITEM_TARGET   = 850;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [3:0] ALL_REGS = 4'b1111;

	typedef enum int {
		FLOW_FREE,
		FLOW_SEND_GAPS,
		FLOW_RECV_STALLS,
		FLOW_BOTH
	} flow_mode_t;

	// One weight with its destination address
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] value;
		logic               last;
	} placed_weight_t;

	// Directed row: a register write or a weight, with an optional typed result
	typedef struct {
		bit                    is_cfg;
		cwr_pkg::cfg_reg_t     idx;
		logic [CFG_DATA_W-1:0] data;
		logic [VALUE_W-1:0]    weight;
		bit                    typed;
		logic [ADDR_W-1:0]     addr;
		bit                    last;
	} stim_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // [7:0] weight_value
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [27:0] dest_address, [35:28] dest_value
	logic                   m_tlast;         // tensor_last

	// Shadow registers and position counters of the model
	logic [KDIM_REG_W-1:0] shadow_height = cwr_pkg::KERNEL_HEIGHT_RST;
	logic [KDIM_REG_W-1:0] shadow_width  = cwr_pkg::KERNEL_WIDTH_RST;
	logic [CHAN_REG_W-1:0] shadow_cin    = cwr_pkg::CHANNELS_IN_RST;
	logic [CHAN_REG_W-1:0] shadow_cout   = cwr_pkg::CHANNELS_OUT_RST;
	logic [3:0]            pos_col       = '0;
	logic [3:0]            pos_row       = '0;
	logic [9:0]            pos_inch      = '0;
	logic [9:0]            pos_outch     = '0;

	placed_weight_t expected_placements[$];
	flow_mode_t     flow_mode      = FLOW_FREE;
	int             items_sent     = 0;
	int             tensors_closed = 0;
	int             mismatch_count = 0;
	int             quiet_cycles   = 0;

	stim_row_t directed_rows [36] = '{
		// reset sizes 3x3, one channel in and out: addresses run straight
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h7F, 1, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h80, 1, 1, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h00, 1, 2, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'hFF, 1, 3, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h01, 1, 4, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h55, 1, 5, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'hAA, 1, 6, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h0F, 1, 7, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'hF0, 1, 8, 1},
		// sizes of zero act as one; two input channels
		'{1, cwr_pkg::REG_KERNEL_HEIGHT, 0,    0, 0, 0, 0},
		'{1, cwr_pkg::REG_KERNEL_WIDTH,  0,    0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_IN,   2,    0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_OUT,  0,    0, 0, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h33, 1, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'hCC, 1, 1, 1},
		// two output channels of single weights
		'{1, cwr_pkg::REG_CHANNELS_IN,   1,    0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_OUT,  2,    0, 0, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h7E, 1, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h81, 1, 1, 1},
		// over-range sizes clamp to the maximum
		'{1, cwr_pkg::REG_KERNEL_HEIGHT, 31,   0, 0, 0, 0},
		'{1, cwr_pkg::REG_KERNEL_WIDTH,  17,   0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_IN,   2047, 0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_OUT,  1100, 0, 0, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h12, 1, 0,   0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h34, 1, 256, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h56, 1, 512, 0},
		// shrink mid-tensor: the input channel counter sits past its new end
		'{1, cwr_pkg::REG_KERNEL_HEIGHT, 1, 0, 0, 0, 0},
		'{1, cwr_pkg::REG_KERNEL_WIDTH,  1, 0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_IN,   2, 0, 0, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'h9A, 0, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'hBC, 0, 0, 0},
		// largest sizes with nonzero counters
		'{1, cwr_pkg::REG_KERNEL_HEIGHT, 16,   0, 0, 0, 0},
		'{1, cwr_pkg::REG_KERNEL_WIDTH,  16,   0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_IN,   1024, 0, 0, 0, 0},
		'{1, cwr_pkg::REG_CHANNELS_OUT,  1024, 0, 0, 0, 0},
		'{0, cwr_pkg::REG_KERNEL_HEIGHT, 0, 8'hDE, 0, 0, 0}
	};

	conv_weight_layout_reorder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Place one weight and advance the counters in source order
	function automatic placed_weight_t place_weight(input logic [VALUE_W-1:0] w);
		int unsigned    h_eff;
		int unsigned    w_eff;
		int unsigned    ci_eff;
		int unsigned    co_eff;
		int unsigned    addr;
		bit             inch_end;
		bit             col_end;
		bit             row_end;
		bit             outch_end;
		placed_weight_t res;
		h_eff  = eff_size(32'(shadow_height), 32'(MAX_KERNEL_DIM));
		w_eff  = eff_size(32'(shadow_width), 32'(MAX_KERNEL_DIM));
		ci_eff = eff_size(32'(shadow_cin), 32'(MAX_CHANNELS));
		co_eff = eff_size(32'(shadow_cout), 32'(MAX_CHANNELS));
		addr = 32'(pos_col) + w_eff * (32'(pos_row) +
			h_eff * (32'(pos_inch) + 32'(pos_outch) * ci_eff));
		inch_end  = (32'(pos_inch) + 32'd1) >= ci_eff;
		col_end   = (32'(pos_col) + 32'd1) >= w_eff;
		row_end   = (32'(pos_row) + 32'd1) >= h_eff;
		outch_end = (32'(pos_outch) + 32'd1) >= co_eff;
		res.addr  = ADDR_W'(addr);
		res.value = w;
		res.last  = inch_end && col_end && row_end && outch_end;
		if (!inch_end) begin
			pos_inch = pos_inch + 10'd1;
		end else begin
			pos_inch = '0;
			if (!col_end) begin
				pos_col = pos_col + 4'd1;
			end else begin
				pos_col = '0;
				if (!row_end) begin
					pos_row = pos_row + 4'd1;
				end else begin
					pos_row = '0;
					if (!outch_end)
						pos_outch = pos_outch + 10'd1;
					else
						pos_outch = '0;
				end
			end
		end
		if (res.last)
			tensors_closed++;
		return res;
	endfunction

	function automatic bit roll(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Size register value: zero, one, maximum, over range or raw
	function automatic logic [CFG_DATA_W-1:0] pick_size(input int unsigned maxv,
		input int unsigned raw_max);
		unique case ($urandom_range(0, 4))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(maxv);
			3: return CFG_DATA_W'($urandom_range(raw_max, maxv + 1));
			default: return CFG_DATA_W'($urandom_range(0, 2047));
		endcase
	endfunction

	// Write one register; keep the write enable high if another write follows
	task automatic write_reg(input cwr_pkg::cfg_reg_t idx,
		input logic [CFG_DATA_W-1:0] data, input bit hold);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		unique case (idx)
			cwr_pkg::REG_KERNEL_HEIGHT: shadow_height = data[KDIM_REG_W-1:0];
			cwr_pkg::REG_KERNEL_WIDTH:  shadow_width  = data[KDIM_REG_W-1:0];
			cwr_pkg::REG_CHANNELS_IN:   shadow_cin    = data[CHAN_REG_W-1:0];
			cwr_pkg::REG_CHANNELS_OUT:  shadow_cout   = data[CHAN_REG_W-1:0];
			default: ;
		endcase
		if (!hold)
			cfg_we <= 1'b0;
	endtask

	// Write the registers selected by mask, bit i for register index i
	task automatic write_sizes(input logic [3:0] mask, input logic [CFG_DATA_W-1:0] h,
		input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] ci,
		input logic [CFG_DATA_W-1:0] co);
		if (mask[0])
			write_reg(cwr_pkg::REG_KERNEL_HEIGHT, h, mask[3:1] != 0);
		if (mask[1])
			write_reg(cwr_pkg::REG_KERNEL_WIDTH, w, mask[3:2] != 0);
		if (mask[2])
			write_reg(cwr_pkg::REG_CHANNELS_IN, ci, mask[3]);
		if (mask[3])
			write_reg(cwr_pkg::REG_CHANNELS_OUT, co, 1'b0);
	endtask

	// Offer one weight, hold it until accepted, then queue its placement
	task automatic send_weight(input logic [VALUE_W-1:0] w, input bit typed,
		input placed_weight_t typed_res);
		placed_weight_t predicted;
		while ((flow_mode == FLOW_SEND_GAPS && roll(85)) ||
			(flow_mode == FLOW_BOTH && roll(22))) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = place_weight(w);
		expected_placements.push_back(typed ? typed_res : predicted);
		items_sent++;
	endtask

	// Drop valid, drain all results, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_placements.size() != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic note_mismatch(input placed_weight_t exp, input bit have_exp);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			if (have_exp) begin
				$display("mismatch: expected addr=%0d value=%0d last=%0b",
					exp.addr, $signed(exp.value), exp.last);
				$display("          got addr=%0d value=%0d last=%0b pad=%h",
					m_tdata[ADDR_W-1:0], $signed(m_tdata[ADDR_W+VALUE_W-1:ADDR_W]),
					m_tlast, m_tdata[OUT_TDATA_W-1:ADDR_W+VALUE_W]);
			end else begin
				$display("unexpected item: addr=%0d value=%0d last=%0b",
					m_tdata[ADDR_W-1:0], $signed(m_tdata[ADDR_W+VALUE_W-1:ADDR_W]), m_tlast);
			end
		end
	endtask

	// Check each returned item against the oldest placement; roll receiver stalls
	always @(posedge clk) begin
		placed_weight_t exp;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_placements.size() == 0) begin
					note_mismatch(exp, 1'b0);
				end else begin
					exp = expected_placements.pop_front();
					if (m_tdata[ADDR_W-1:0] !== exp.addr ||
						m_tdata[ADDR_W+VALUE_W-1:ADDR_W] !== exp.value ||
						m_tdata[OUT_TDATA_W-1:ADDR_W+VALUE_W] !== '0 ||
						m_tlast !== exp.last)
						note_mismatch(exp, 1'b1);
				end
			end
			m_tready <= !((flow_mode == FLOW_RECV_STALLS && roll(85)) ||
				(flow_mode == FLOW_BOTH && roll(22)));
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_conv_weight_layout_reorder failed");
				$finish;
			end
		end
	end

	initial begin
		placed_weight_t typed_res;
		int             phase;
		int             kind;
		int             target;
		int             count;
		phase = 0;

		// Hold reset, then release on a clock edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int r = 0; r < $size(directed_rows); r++) begin
			if (directed_rows[r].is_cfg) begin
				if (r > 0 && !directed_rows[r-1].is_cfg)
					wait_idle();
				write_reg(directed_rows[r].idx, directed_rows[r].data,
					(r + 1 < $size(directed_rows)) && directed_rows[r+1].is_cfg);
			end else begin
				typed_res.addr  = directed_rows[r].addr;
				typed_res.value = directed_rows[r].weight;
				typed_res.last  = directed_rows[r].last;
				send_weight(directed_rows[r].weight, directed_rows[r].typed, typed_res);
			end
		end

		// Random phases, flow pattern rotating phase by phase
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			flow_mode = flow_mode_t'(phase % 4);
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				// small sizes, run until one or two tensors close
				write_sizes(ALL_REGS, CFG_DATA_W'($urandom_range(1, 3)),
					CFG_DATA_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom_range(1, 3)),
					CFG_DATA_W'($urandom_range(1, 2)));
				target = tensors_closed + $urandom_range(1, 2);
				while (tensors_closed < target)
					send_weight(VALUE_W'($urandom_range(0, 255)), 1'b0, '0);
			end else begin
				if (kind < 75)
					write_sizes(ALL_REGS, pick_size(MAX_KERNEL_DIM, 31),
						pick_size(MAX_KERNEL_DIM, 31), pick_size(MAX_CHANNELS, 2047),
						pick_size(MAX_CHANNELS, 2047));
				else if (kind < 88)
					write_sizes(4'($urandom_range(1, 15)),
						CFG_DATA_W'($urandom_range(0, 2047)),
						CFG_DATA_W'($urandom_range(0, 2047)),
						CFG_DATA_W'($urandom_range(0, 2047)),
						CFG_DATA_W'($urandom_range(0, 2047)));
				else if (kind < 94)
					write_sizes(ALL_REGS, CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1),
						CFG_DATA_W'(MAX_CHANNELS));
				else
					write_sizes(ALL_REGS, CFG_DATA_W'(1), CFG_DATA_W'(1),
						CFG_DATA_W'(MAX_CHANNELS), CFG_DATA_W'(1));
				count = (kind < 88) ? $urandom_range(10, 30) : $urandom_range(40, 90);
				repeat (count)
					send_weight(VALUE_W'($urandom_range(0, 255)), 1'b0, '0);
			end
			phase++;
		end

		// Drain and report
		wait_idle();
		if (mismatch_count == 0 && expected_placements.size() == 0)
			$display("tb_conv_weight_layout_reorder passed");
		else
			$display("tb_conv_weight_layout_reorder failed");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/cwr_pkg.sv
sv/cwr_ctrl.sv
sv/cwr_datapath.sv
sv/conv_weight_layout_reorder.sv
dv/tb_conv_weight_layout_reorder.sv
